/* src/oadsr_pkg.sv */
// ----------------------------------------------------------------------------
// oadsr_pkg
// Shared types, register codes, field widths and reset values for the
// oscillator / ADSR voice sample generator.
// ----------------------------------------------------------------------------
package oadsr_pkg;

    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 23;

    localparam int SAMPLE_INDEX_W = 22;
    localparam int BEAT_W         = 20;
    localparam int FREQ_W         = 23;
    localparam int MIX_W          = 16;
    localparam int LEVEL_W        = 16;
    localparam int FRAC_W         = 16;
    localparam int FRAC_SH        = 12;

    localparam int IN_TDATA_W     = 88;
    localparam int OUT_TDATA_W    = 16;

    localparam int BEAT_LO        = SAMPLE_INDEX_W;
    localparam int FREQ_LO        = BEAT_LO + BEAT_W;
    localparam int MIX_LO         = FREQ_LO + FREQ_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WAVE_SHAPE   = 3'd0,
        REG_VOLUME       = 3'd1,
        REG_ATTACK       = 3'd2,
        REG_DECAY        = 3'd3,
        REG_SUSTAIN      = 3'd4,
        REG_RELEASE      = 3'd5,
        REG_CLIP         = 3'd6,
        REG_FIXED_FREQ   = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SAW      = 2'd1,
        WAVE_TRIANGLE = 2'd2,
        WAVE_SQUARE   = 2'd3
    } wave_shape_t;

    typedef enum logic [2:0] {
        ENV_ATTACK,
        ENV_DECAY,
        ENV_SUSTAIN,
        ENV_RELEASE,
        ENV_SILENT
    } env_mode_t;

    localparam logic [LEVEL_W-1:0] RST_VOLUME  = 16'd16384;
    localparam logic [FRAC_W-1:0]  RST_ATTACK  = 16'd128;
    localparam logic [FRAC_W-1:0]  RST_DECAY   = 16'd1365;
    localparam logic [LEVEL_W-1:0] RST_SUSTAIN = 16'd24576;
    localparam logic [FRAC_W-1:0]  RST_RELEASE = 16'd128;
    localparam logic [LEVEL_W-1:0] RST_CLIP    = 16'd0;
    localparam logic [FREQ_W-1:0]  RST_FIXED   = 23'd0;

    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

endpackage

/* src/oscillator_adsr_voice_sample.sv */
// ----------------------------------------------------------------------------
// oscillator_adsr_voice_sample
// One voice sample per beat: waveform at note or fixed frequency, scaled by
// volume and a linear ADSR envelope, clipped, saturated and mixed in.
// ----------------------------------------------------------------------------
// Fully pipelined: one sample per clock while the output is not stalled. The
// envelope ramps are formed by a 16-stage restoring divider; the phase wrap
// and the saw/sine index use reciprocal multiplies with compare/subtract
// correction. The whole pipe advances when the output register is empty or
// being taken. Sine table depth must be a power of two. Config writes are
// taken every cycle (cfg_ready is tied high).
// ----------------------------------------------------------------------------
module oscillator_adsr_voice_sample #(
    parameter int SAMPLE_RATE_HZ   = 48000,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // sample_index[21:0], beat_samples[41:22], note_frequency[64:42],
    // mix_in[80:65], zero pad[87:81]
    input  logic [oadsr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // mixed_sample[15:0]
    output logic [oadsr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [oadsr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [oadsr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import oadsr_pkg::*;

    localparam longint unsigned MOD_M = longint'(SAMPLE_RATE_HZ) * 256;
    localparam int M_W     = $clog2(MOD_M + 1);
    localparam int PROD_W  = SAMPLE_INDEX_W + FREQ_W;
    localparam int K_SH    = M_W - 1;
    localparam int X_W     = PROD_W - K_SH;
    localparam int RCP_SH  = 26;
    localparam int RCPQ_W  = RCP_SH + 1;
    localparam longint unsigned RCP_Q = (64'd1 << (K_SH + RCP_SH)) / MOD_M;
    localparam int RED_W   = M_W + 2;
    localparam int RCPS_W  = 18;
    localparam longint unsigned RCP_S = (64'd1 << (M_W + 16)) / MOD_M;

    localparam int DB      = $clog2(SINE_TABLE_DEPTH);
    localparam int QTR     = SINE_TABLE_DEPTH / 4;
    localparam int IDX_W   = DB - 1;

    localparam int W_W     = 17;
    localparam int SEG_W   = FRAC_W + BEAT_W - FRAC_SH;
    localparam int MULA_W  = SEG_W + 1;
    localparam int MULB_W  = LEVEL_W + 1;
    localparam int MUL_W   = MULA_W + MULB_W;
    localparam int NUM_W   = SEG_W + 17;
    localparam int DIV_STEPS = LEVEL_W;

    localparam int ST_DIV0 = 5;
    localparam int ST_W    = 10;
    localparam int ST_E    = ST_DIV0 + DIV_STEPS - 1;
    localparam int ST_VE   = ST_E + 1;
    localparam int ST_MAG  = ST_VE + 1;
    localparam int ST_LVL  = ST_MAG + 1;
    localparam int ST_OUT  = ST_LVL + 1;
    localparam int NST     = ST_OUT + 1;

    // ---------------- sine quarter table ----------------
    function automatic logic [15:0] sine_mag(input int idx);
        longint unsigned rem, x, x2, t, s, v;
        rem = 64'(4 * idx);
        x   = rem * HALF_PI_Q30 / SINE_TABLE_DEPTH;
        x2  = (x * x) >> 30;
        t   = Q30_ONE;
        t   = Q30_ONE - ((x2 * t) >> 30) / 110;
        t   = Q30_ONE - ((x2 * t) >> 30) / 72;
        t   = Q30_ONE - ((x2 * t) >> 30) / 42;
        t   = Q30_ONE - ((x2 * t) >> 30) / 20;
        t   = Q30_ONE - ((x2 * t) >> 30) / 6;
        s   = (x * t) >> 30;
        v   = (s + 64'd16384) >> 15;
        if (v > 64'd32768)
        begin
            v = 64'd32768;
        end
        return v[15:0];
    endfunction

    logic [15:0] sine_lut [0:QTR];

    for (genvar g = 0; g <= QTR; g++)
    begin : g_sine
        localparam logic [15:0] SINE_VAL = sine_mag(g);
        assign sine_lut[g] = SINE_VAL;
    end

    // ---------------- configuration ----------------
    wave_shape_t          wave_shape_reg;
    logic [LEVEL_W-1:0]   volume_reg;
    logic [FRAC_W-1:0]    attack_reg;
    logic [FRAC_W-1:0]    decay_reg;
    logic [LEVEL_W-1:0]   sustain_reg;
    logic [FRAC_W-1:0]    release_reg;
    logic [LEVEL_W-1:0]   clip_reg;
    logic [FREQ_W-1:0]    fixed_freq_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_shape_reg <= WAVE_SINE;
            volume_reg     <= RST_VOLUME;
            attack_reg     <= RST_ATTACK;
            decay_reg      <= RST_DECAY;
            sustain_reg    <= RST_SUSTAIN;
            release_reg    <= RST_RELEASE;
            clip_reg       <= RST_CLIP;
            fixed_freq_reg <= RST_FIXED;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WAVE_SHAPE: wave_shape_reg <= wave_shape_t'(cfg_data[1:0]);
                REG_VOLUME:     volume_reg     <= cfg_data[LEVEL_W-1:0];
                REG_ATTACK:     attack_reg     <= cfg_data[FRAC_W-1:0];
                REG_DECAY:      decay_reg      <= cfg_data[FRAC_W-1:0];
                REG_SUSTAIN:    sustain_reg    <= cfg_data[LEVEL_W-1:0];
                REG_RELEASE:    release_reg    <= cfg_data[FRAC_W-1:0];
                REG_CLIP:       clip_reg       <= cfg_data[LEVEL_W-1:0];
                REG_FIXED_FREQ: fixed_freq_reg <= cfg_data[FREQ_W-1:0];
                default:        ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic [NST-1:0] vld_reg;
    logic           adv;
    logic           accept;

    assign adv           = ~vld_reg[NST-1] | m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid & adv;
    assign m_axis_tvalid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-2:0], accept};
        end
    end

    // ---------------- pipeline registers ----------------
    logic [SAMPLE_INDEX_W-1:0] p0_reg, p1_reg;
    logic [BEAT_W-1:0]         b0_reg, b1_reg;
    logic [FREQ_W-1:0]         f0_reg;
    logic [MIX_W-1:0]          mix_reg [0:ST_LVL];

    logic [SAMPLE_INDEX_W+11:0] pf_lo_reg;
    logic [SAMPLE_INDEX_W+10:0] pf_hi_reg;
    logic [FRAC_W+BEAT_W-1:0]   am_reg, dm_reg, rm_reg;

    logic [PROD_W-1:0]          prod2_reg, prod3_reg, prod4_reg;
    env_mode_t                  mode2_reg, mode3_reg, mode4_reg;
    logic signed [MULA_W-1:0]   opa2_reg;
    logic signed [MULB_W-1:0]   opb2_reg;
    logic [SEG_W-1:0]           base2_reg, base3_reg;
    logic [SEG_W-1:0]           dv2_reg, dv3_reg, dv4_reg;

    logic signed [MUL_W-1:0]    mul3_reg;
    logic [X_W-1:0]             q3_reg;
    logic [NUM_W-1:0]           num4_reg;
    logic [PROD_W-1:0]          qm4_reg;

    logic [RED_W-1:0]           red5_reg;
    logic [M_W-1:0]             r6_reg, r7_reg, r8_reg;
    logic [15:0]                sp7_reg, sp8_reg, s9_reg;
    logic                       sq7_reg, sq8_reg, sq9_reg;
    logic [M_W+15:0]            sm8_reg;
    logic signed [W_W-1:0]      w_reg [ST_W:ST_VE];

    logic [NUM_W-1:0]           rem_reg  [0:DIV_STEPS-1];
    logic [LEVEL_W-1:0]         quo_reg  [0:DIV_STEPS-1];
    logic [SEG_W-1:0]           dvs_reg  [0:DIV_STEPS-1];
    env_mode_t                  dmode_reg[0:DIV_STEPS-1];

    logic [2*LEVEL_W-1:0]       ve_reg;
    logic [3*LEVEL_W-1:0]       mag_reg;
    logic                       neg22_reg, neg23_reg;
    logic [LEVEL_W-1:0]         lvl_reg;
    logic [MIX_W-1:0]           out_reg;

    // ---------------- combinational next values ----------------
    logic [FREQ_W-1:0]          f_next;
    logic [PROD_W-1:0]          prod_next;
    logic [SEG_W-1:0]           a_seg, dd_seg, tl_seg;
    logic [SEG_W:0]             d_sum;
    logic                       lt_a, lt_d, lt_b;
    logic signed [SEG_W+1:0]    tr_full;
    logic [SAMPLE_INDEX_W-1:0]  pa_diff;
    env_mode_t                  mode_next;
    logic signed [MULA_W-1:0]   opa_next;
    logic signed [MULB_W-1:0]   opb_next;
    logic [SEG_W-1:0]           base_next, dv_next;
    logic [X_W+RCPQ_W-1:0]      qprod;
    logic [X_W+M_W-1:0]         qm_full;
    logic signed [MUL_W:0]      num_full;
    logic [M_W-1:0]             r_next;
    logic [M_W+RCPS_W-1:0]      sprod;
    logic [M_W+15:0]            sdiff;
    logic [15:0]                s_next;

    logic [DB-1:0]              sk;
    logic [1:0]                 quad;
    logic [IDX_W-1:0]           sidx;
    logic [15:0]                sine_v;
    logic signed [W_W-1:0]      sine_w, saw_w, tri_w, sq_w, w_next;
    logic [W_W-1:0]             saw_abs;
    logic [W_W:0]               tri_full;

    logic [NUM_W-1:0]           rem_in  [0:DIV_STEPS-1];
    logic [LEVEL_W-1:0]         quo_in  [0:DIV_STEPS-1];
    logic [SEG_W-1:0]           dvs_in  [0:DIV_STEPS-1];
    env_mode_t                  dmode_in[0:DIV_STEPS-1];
    logic [NUM_W:0]             trial   [0:DIV_STEPS-1];
    logic [NUM_W-1:0]           rem_next[0:DIV_STEPS-1];
    logic [LEVEL_W-1:0]         quo_next[0:DIV_STEPS-1];

    logic [LEVEL_W-1:0]         e_next;
    logic [LEVEL_W-1:0]         wabs;
    logic [3*LEVEL_W:0]         rnd_sum;
    logic [3*LEVEL_W-30:0]      rnd_lvl;
    logic [3*LEVEL_W-30:0]      clip_lvl;
    logic [LEVEL_W-1:0]         lvl_next;
    logic [2*LEVEL_W-1:0]       v_full;
    logic [MIX_W-1:0]           v_mag, out_next;

    assign f_next = (fixed_freq_reg != '0) ? fixed_freq_reg
                                           : s_axis_tdata[FREQ_LO +: FREQ_W];

    // phase product and envelope segment bounds
    always_comb
    begin
        prod_next = {11'b0, pf_lo_reg} + {pf_hi_reg, 12'b0};
        a_seg     = am_reg[FRAC_W+BEAT_W-1:FRAC_SH];
        dd_seg    = dm_reg[FRAC_W+BEAT_W-1:FRAC_SH];
        tl_seg    = rm_reg[FRAC_W+BEAT_W-1:FRAC_SH];
        d_sum     = {1'b0, a_seg} + {1'b0, dd_seg};
        lt_a      = {{(SEG_W-SAMPLE_INDEX_W){1'b0}}, p1_reg} < a_seg;
        lt_d      = {{(SEG_W+1-SAMPLE_INDEX_W){1'b0}}, p1_reg} < d_sum;
        lt_b      = {{(SAMPLE_INDEX_W-BEAT_W){1'b0}}, b1_reg} > p1_reg;
        tr_full   = $signed({2'b0, tl_seg})
                  + $signed({{(SEG_W+2-BEAT_W){1'b0}}, b1_reg})
                  - $signed({{(SEG_W+2-SAMPLE_INDEX_W){1'b0}}, p1_reg});
        pa_diff   = p1_reg - a_seg[SAMPLE_INDEX_W-1:0];

        mode_next = ENV_SILENT;
        opa_next  = '0;
        opb_next  = '0;
        base_next = '0;
        dv_next   = tl_seg;
        if (lt_a)
        begin
            mode_next = ENV_ATTACK;
            base_next = {{(SEG_W-SAMPLE_INDEX_W){1'b0}}, p1_reg};
            dv_next   = a_seg;
        end
        else if (lt_d)
        begin
            mode_next = ENV_DECAY;
            base_next = dd_seg;
            dv_next   = dd_seg;
            opa_next  = $signed({{(MULA_W-SAMPLE_INDEX_W){1'b0}}, pa_diff});
            opb_next  = $signed({1'b0, sustain_reg}) - $signed(MULB_W'(32768));
        end
        else if (lt_b)
        begin
            mode_next = ENV_SUSTAIN;
        end
        else if (tr_full > 0)
        begin
            mode_next = ENV_RELEASE;
            opa_next  = tr_full[MULA_W-1:0];
            opb_next  = $signed({1'b0, sustain_reg});
        end
    end

    // phase reduction and saw/sine index
    always_comb
    begin
        qprod    = prod2_reg[PROD_W-1:K_SH] * RCPQ_W'(RCP_Q);
        qm_full  = q3_reg * M_W'(MOD_M);
        num_full = $signed({{(MUL_W+1-SEG_W-15){1'b0}}, base3_reg, 15'b0})
                 + $signed({mul3_reg[MUL_W-1], mul3_reg});
        if (red5_reg >= RED_W'(2 * MOD_M))
        begin
            r_next = M_W'(red5_reg - RED_W'(2 * MOD_M));
        end
        else if (red5_reg >= RED_W'(MOD_M))
        begin
            r_next = M_W'(red5_reg - RED_W'(MOD_M));
        end
        else
        begin
            r_next = red5_reg[M_W-1:0];
        end
        sprod  = r6_reg * RCPS_W'(RCP_S);
        sdiff  = {r8_reg, 16'b0} - sm8_reg;
        s_next = (sdiff >= (M_W+16)'(MOD_M)) ? sp8_reg + 16'd1 : sp8_reg;
    end

    // waveform select
    always_comb
    begin
        sk       = s9_reg[15 -: DB];
        quad     = sk[DB-1 -: 2];
        sidx     = quad[0] ? IDX_W'(QTR) - {1'b0, sk[DB-3:0]} : {1'b0, sk[DB-3:0]};
        sine_v   = sine_lut[sidx];
        sine_w   = quad[1] ? -$signed({1'b0, sine_v}) : $signed({1'b0, sine_v});
        saw_w    = $signed({1'b0, s9_reg}) - $signed(W_W'(32768));
        saw_abs  = s9_reg[15] ? {2'b0, s9_reg[14:0]} : W_W'(32768) - {1'b0, s9_reg};
        tri_full = {saw_abs, 1'b0} - (W_W+1)'(32768);
        tri_w    = $signed(tri_full[W_W-1:0]);
        sq_w     = sq9_reg ? $signed(W_W'(32768)) : -$signed(W_W'(32768));
        case (wave_shape_reg)
            WAVE_SINE:     w_next = sine_w;
            WAVE_SAW:      w_next = saw_w;
            WAVE_TRIANGLE: w_next = tri_w;
            WAVE_SQUARE:   w_next = sq_w;
            default:       w_next = sq_w;
        endcase
    end

    // restoring divider, one quotient bit per stage
    always_comb
    begin
        rem_in[0]   = num4_reg;
        quo_in[0]   = '0;
        dvs_in[0]   = dv4_reg;
        dmode_in[0] = mode4_reg;
        for (int j = 1; j < DIV_STEPS; j++)
        begin
            rem_in[j]   = rem_reg[j-1];
            quo_in[j]   = quo_reg[j-1];
            dvs_in[j]   = dvs_reg[j-1];
            dmode_in[j] = dmode_reg[j-1];
        end
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            trial[j]    = {1'b0, rem_in[j]}
                        - ({{(NUM_W+1-SEG_W){1'b0}}, dvs_in[j]} << (DIV_STEPS-1-j));
            rem_next[j] = trial[j][NUM_W] ? rem_in[j] : trial[j][NUM_W-1:0];
            quo_next[j] = quo_in[j];
            quo_next[j][DIV_STEPS-1-j] = ~trial[j][NUM_W];
        end
    end

    // envelope, level and mix
    always_comb
    begin
        case (dmode_reg[DIV_STEPS-1])
            ENV_ATTACK,
            ENV_DECAY,
            ENV_RELEASE: e_next = quo_reg[DIV_STEPS-1];
            ENV_SUSTAIN: e_next = sustain_reg;
            default:     e_next = '0;
        endcase
        wabs     = w_reg[ST_VE][W_W-1] ? LEVEL_W'(-w_reg[ST_VE]) : LEVEL_W'(w_reg[ST_VE]);
        rnd_sum  = {1'b0, mag_reg} + (3*LEVEL_W+1)'(64'd1 << 29);
        rnd_lvl  = rnd_sum[3*LEVEL_W:30];
        clip_lvl = (clip_reg != '0 && rnd_lvl > {3'b0, clip_reg}) ? {3'b0, clip_reg}
                                                                 : rnd_lvl;
        lvl_next = (clip_lvl > (3*LEVEL_W-29)'(32768)) ? LEVEL_W'(32768)
                                                       : clip_lvl[LEVEL_W-1:0];
        v_full   = {1'b0, lvl_reg, 15'b0} - {16'b0, lvl_reg} + 32'd16384;
        v_mag    = v_full[30:15];
        out_next = neg23_reg ? mix_reg[ST_LVL] - v_mag : mix_reg[ST_LVL] + v_mag;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p0_reg     <= s_axis_tdata[SAMPLE_INDEX_W-1:0];
            b0_reg     <= s_axis_tdata[BEAT_LO +: BEAT_W];
            f0_reg     <= f_next;
            mix_reg[0] <= s_axis_tdata[MIX_LO +: MIX_W];
            for (int i = 1; i <= ST_LVL; i++)
            begin
                mix_reg[i] <= mix_reg[i-1];
            end

            pf_lo_reg <= p0_reg * f0_reg[11:0];
            pf_hi_reg <= p0_reg * f0_reg[FREQ_W-1:12];
            am_reg    <= attack_reg * b0_reg;
            dm_reg    <= decay_reg * b0_reg;
            rm_reg    <= release_reg * b0_reg;
            p1_reg    <= p0_reg;
            b1_reg    <= b0_reg;

            prod2_reg <= prod_next;
            mode2_reg <= mode_next;
            opa2_reg  <= opa_next;
            opb2_reg  <= opb_next;
            base2_reg <= base_next;
            dv2_reg   <= dv_next;

            mul3_reg  <= opa2_reg * opb2_reg;
            q3_reg    <= qprod[RCP_SH +: X_W];
            prod3_reg <= prod2_reg;
            mode3_reg <= mode2_reg;
            base3_reg <= base2_reg;
            dv3_reg   <= dv2_reg;

            num4_reg  <= num_full[NUM_W-1:0];
            qm4_reg   <= qm_full[PROD_W-1:0];
            prod4_reg <= prod3_reg;
            mode4_reg <= mode3_reg;
            dv4_reg   <= dv3_reg;

            red5_reg  <= prod4_reg[RED_W-1:0] - qm4_reg[RED_W-1:0];
            r6_reg    <= r_next;
            sp7_reg   <= sprod[M_W +: 16];
            sq7_reg   <= ({1'b0, r6_reg, 1'b0} <= (M_W+2)'(MOD_M));
            r7_reg    <= r6_reg;
            sm8_reg   <= sp7_reg * M_W'(MOD_M);
            sp8_reg   <= sp7_reg;
            sq8_reg   <= sq7_reg;
            r8_reg    <= r7_reg;
            s9_reg    <= s_next;
            sq9_reg   <= sq8_reg;

            w_reg[ST_W] <= w_next;
            for (int i = ST_W + 1; i <= ST_VE; i++)
            begin
                w_reg[i] <= w_reg[i-1];
            end

            for (int j = 0; j < DIV_STEPS; j++)
            begin
                rem_reg[j]   <= rem_next[j];
                quo_reg[j]   <= quo_next[j];
                dvs_reg[j]   <= dvs_in[j];
                dmode_reg[j] <= dmode_in[j];
            end

            ve_reg    <= volume_reg * e_next;
            mag_reg   <= ve_reg * wabs;
            neg22_reg <= w_reg[ST_VE][W_W-1];
            lvl_reg   <= lvl_next;
            neg23_reg <= neg22_reg;
            out_reg   <= out_next;
        end
    end

    assign m_axis_tdata = out_reg;

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: oscillator_adsr_voice_sample testbench
// Drives voice sample requests through the input stream, predicts each mixed
// sample from an integer model of the waveform, envelope and saturation held
// in a scoreboard, and checks every output beat in order. Runs a directed set
// at reset settings, then random phases with random and extreme register
// settings, with random input bursts and output stalls.
// ----------------------------------------------------------------------------
import oadsr_pkg::*;

typedef struct packed {
    logic signed [MIX_W-1:0]          mix;
    logic [FREQ_W-1:0]                freq;
    logic [BEAT_W-1:0]                beat;
    logic [SAMPLE_INDEX_W-1:0]        pos;
} voice_req_t;

class voice_scoreboard;
    localparam longint RATE  = 48000;
    localparam longint DEPTH = 1024;

    logic [1:0]          shape;
    logic [LEVEL_W-1:0]  volume;
    logic [FRAC_W-1:0]   attack;
    logic [FRAC_W-1:0]   decay;
    logic [LEVEL_W-1:0]  sustain;
    logic [FRAC_W-1:0]   release_frac;
    logic [LEVEL_W-1:0]  clip;
    logic [FREQ_W-1:0]   fixed_freq;
    logic [MIX_W-1:0]    expected_samples[$];
    int                  errors;

    function new();
        shape        = WAVE_SINE;
        volume       = RST_VOLUME;
        attack       = RST_ATTACK;
        decay        = RST_DECAY;
        sustain      = RST_SUSTAIN;
        release_frac = RST_RELEASE;
        clip         = RST_CLIP;
        fixed_freq   = RST_FIXED;
        errors       = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_WAVE_SHAPE: shape        = d[1:0];
            REG_VOLUME:     volume       = d[15:0];
            REG_ATTACK:     attack       = d[15:0];
            REG_DECAY:      decay        = d[15:0];
            REG_SUSTAIN:    sustain      = d[15:0];
            REG_RELEASE:    release_frac = d[15:0];
            REG_CLIP:       clip         = d[15:0];
            REG_FIXED_FREQ: fixed_freq   = d;
            default: ;
        endcase
    endfunction

    function longint sine_value(longint unsigned k);
        longint unsigned divs[5] = '{110, 72, 42, 20, 6};
        longint unsigned n, quad, rem, x, x2, t, s, v;
        n = 4 * k;
        quad = (n / DEPTH) & 3;
        rem = n % DEPTH;
        if (quad & 1)
            rem = DEPTH - rem;
        x = rem * HALF_PI_Q30 / DEPTH;
        x2 = (x * x) >> 30;
        t = Q30_ONE;
        for (int i = 0; i < 5; i++)
            t = Q30_ONE - ((x2 * t) >> 30) / divs[i];
        s = (x * t) >> 30;
        v = (s + 16384) >> 15;
        if (v > 32768)
            v = 32768;
        return (quad >= 2) ? -longint'(v) : longint'(v);
    endfunction

    function longint envelope_level(longint p, longint b);
        longint a, d, tail, span;
        a = (longint'(attack) * b) >> 12;
        d = a + ((longint'(decay) * b) >> 12);
        tail = (longint'(release_frac) * b) >> 12;
        if (p < a)
            return (32768 * p) / a;
        if (p < d) begin
            span = d - a;
            return (32768 * span + (p - a) * (longint'(sustain) - 32768)) / span;
        end
        if (p < b)
            return sustain;
        if (p - b >= tail)
            return 0;
        return (longint'(sustain) * (tail - (p - b))) / tail;
    endfunction

    function logic [MIX_W-1:0] mixed_sample(voice_req_t q);
        longint m, f, r, saw, w, e, prod, mag, lvl, v;
        m = 256 * RATE;
        f = (fixed_freq != 0) ? fixed_freq : q.freq;
        r = (longint'(q.pos) * f) % m;
        saw = (r * 65536) / m - 32768;
        case (shape)
            WAVE_SINE:     w = sine_value((r * DEPTH) / m);
            WAVE_SAW:      w = saw;
            WAVE_TRIANGLE: w = 2 * (saw < 0 ? -saw : saw) - 32768;
            default:       w = (2 * r <= m) ? 32768 : -32768;
        endcase
        e = envelope_level(q.pos, q.beat);
        prod = longint'(volume) * w * e;
        mag = (prod < 0) ? -prod : prod;
        lvl = (mag + (64'sd1 <<< 29)) >>> 30;
        if (clip != 0 && lvl > clip)
            lvl = clip;
        if (lvl > 32768)
            lvl = 32768;
        v = (lvl * 32767 + 16384) >>> 15;
        return (prod < 0) ? (q.mix - v) : (q.mix + v);
    endfunction

    function void note_request(voice_req_t q);
        expected_samples.push_back(mixed_sample(q));
    endfunction

    function void check_sample(logic [MIX_W-1:0] got);
        logic [MIX_W-1:0] exp_s;
        if (expected_samples.size() == 0) begin
            $display("%0t: unexpected output beat, actual %0d", $time, $signed(got));
            errors++;
            return;
        end
        exp_s = expected_samples.pop_front();
        if (got !== exp_s) begin
            $display("%0t: mixed_sample mismatch, expected %0d, actual %0d",
                     $time, $signed(exp_s), $signed(got));
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int LIMIT = 800000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    cfg_reg_t               cfg_index = REG_WAVE_SHAPE;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    voice_scoreboard sb = new();
    int  cycles = 0;
    int  burst_left = 0;
    int  stall_mode = 0;

    oscillator_adsr_voice_sample uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("oscillator_adsr_voice_sample test failed");
            $finish;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_sample(m_axis_tdata);
    end

    // output stall pattern: free-running, random, or mostly stalled
    always @(negedge clk)
    begin
        if (cycles % 300 == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, d);
        @(negedge clk);
    endtask

    task automatic send_req(voice_req_t q);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, q};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_request(q);
        @(negedge clk);
    endtask

    task automatic send(int pos, int beat, int freq, int mix);
        voice_req_t q;
        q.pos = pos;
        q.beat = beat;
        q.freq = freq;
        q.mix = mix;
        send_req(q);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_samples.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic voice_req_t random_req();
        voice_req_t q;
        int b;
        if ($urandom_range(0, 9) < 2)
        begin
            q.pos  = $urandom;
            q.beat = ($urandom_range(0, 3) == 0) ? 20'hFFFFF : $urandom_range(1, 1048575);
            q.freq = $urandom_range(0, 6144000);
        end
        else
        begin
            b = $urandom_range(1, 3000);
            q.beat = b;
            q.pos  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, b * 17)
                                                : $urandom_range(0, b * 3);
            case ($urandom_range(0, 9))
                0:       q.freq = 0;
                1:       q.freq = 6144000;
                default: q.freq = $urandom_range(0, 512000);
            endcase
        end
        q.mix = $urandom;
        return q;
    endfunction

    task automatic random_settings(int ph);
        write_reg(REG_WAVE_SHAPE, ph % 4);
        case (ph)
            1:
            begin
                write_reg(REG_VOLUME, 65535);
                write_reg(REG_ATTACK, 65535);
                write_reg(REG_DECAY, 65535);
                write_reg(REG_SUSTAIN, 65535);
                write_reg(REG_RELEASE, 65535);
                write_reg(REG_CLIP, 32768);
                write_reg(REG_FIXED_FREQ, 6144000);
            end
            2:
            begin
                write_reg(REG_VOLUME, 0);
                write_reg(REG_ATTACK, 0);
                write_reg(REG_DECAY, 0);
                write_reg(REG_SUSTAIN, 0);
                write_reg(REG_RELEASE, 0);
                write_reg(REG_CLIP, 1);
                write_reg(REG_FIXED_FREQ, 0);
            end
            default:
            begin
                write_reg(REG_VOLUME, $urandom_range(0, 65535));
                write_reg(REG_ATTACK, ($urandom_range(0, 3) == 0) ?
                          $urandom_range(0, 65535) : $urandom_range(0, 8192));
                write_reg(REG_DECAY, ($urandom_range(0, 3) == 0) ?
                          $urandom_range(0, 65535) : $urandom_range(0, 8192));
                write_reg(REG_SUSTAIN, $urandom_range(0, 65535));
                write_reg(REG_RELEASE, ($urandom_range(0, 3) == 0) ?
                          $urandom_range(0, 65535) : $urandom_range(0, 8192));
                write_reg(REG_CLIP, ($urandom_range(0, 1) == 0) ?
                          0 : $urandom_range(0, 32768));
                write_reg(REG_FIXED_FREQ, ($urandom_range(0, 2) == 0) ?
                          $urandom_range(0, 6144000) : 0);
            end
        endcase
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: attack 31, decay 333, release 31 samples at B = 1000
        send(0, 1000, 112640, 0);
        send(15, 1000, 112640, 32767);
        send(31, 1000, 112640, -32768);
        send(100, 1000, 112640, 1);
        send(500, 1000, 112640, -1);
        send(1000, 1000, 112640, 0);
        send(1010, 1000, 112640, 100);
        send(1031, 1000, 112640, 100);
        send(1100, 1000, 112640, -100);
        send(4194303, 1048575, 6144000, 32767);
        send(1234, 0, 112640, -5);
        send(300, 1000, 0, 0);
        send(77, 1, 6144000, -32768);
        send(0, 1048575, 0, -1);
        send(4194303, 1, 0, 0);
        send(6000, 1048575, 256, 0);
        send(12000, 1048575, 256, 0);
        send(24000, 1048575, 256, 0);
        send(36000, 1048575, 256, 0);
        send(47999, 1048575, 256, 12345);
        drain();

        for (int ph = 0; ph < 10; ph++)
        begin
            random_settings(ph);
            for (int i = 0; i < 180; i++)
                send_req(random_req());
            drain();
        end

        repeat (40) @(posedge clk);
        if (sb.errors == 0)
            $display("oscillator_adsr_voice_sample test passed");
        else
            $display("oscillator_adsr_voice_sample test failed");
        $finish;
    end
endmodule

/* filelist.f */
src/oadsr_pkg.sv
src/oscillator_adsr_voice_sample.sv
tb/tb.sv
